### hw/rtl/fte_pkg.sv
package fte_pkg;

    // Store depth and derived widths.
    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int IDX_W       = 11;
    localparam int DATA_W      = 32;
    // Walk indices need two spare bits so that an upward step past the size never wraps.
    localparam int WALK_W      = (ADDR_W + 2 > IDX_W) ? ADDR_W + 2 : IDX_W;

    localparam logic [WALK_W-1:0] N_MAX      = WALK_W'(MAX_ENTRIES);
    localparam logic [WALK_W-1:0] K_TOP      = WALK_W'(1) << ADDR_W;
    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(MAX_ENTRIES - 1);
    localparam logic [IDX_W-1:0]  SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_PREFIX = 2'd1,
        OP_RANGE  = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_SRCH_RD,
        ST_SRCH_EV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t                      opcode;
        logic [IDX_W-1:0]         index;
        logic [IDX_W-1:0]         index_high;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sum_result;
        logic [IDX_W-1:0]         position;
        logic                     bad_index;
    } rsp_t;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              positive;
    } alu_rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Tree positions start at one, memory addresses at zero.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [WALK_W-1:0] i);
        logic [WALK_W-1:0] t;
        t = i - WALK_W'(1);
        return t[ADDR_W-1:0];
    endfunction

    // Lowest set bit of a walk index.
    function automatic logic [WALK_W-1:0] low_bit(input logic [WALK_W-1:0] i);
        return i & (~i + WALK_W'(1));
    endfunction

    // Limit a sum end to the size in use.
    function automatic logic [WALK_W-1:0] clamp_idx(input logic [IDX_W-1:0] x,
                                                    input logic [WALK_W-1:0] n);
        logic [WALK_W-1:0] xw;
        xw = WALK_W'(x);
        return (xw > n) ? n : xw;
    endfunction

endpackage

### hw/rtl/fenwick_tree_engine.sv
// Binary indexed tree engine over a store of 1024 signed 32-bit counts. Each request
// transaction carries one operation (point add, prefix sum, range sum or lower-bound
// search) and yields exactly one response transaction. After reset the block clears
// the store, one entry per cycle, with req_ready low; configuration writes are taken
// at any time. Walks stream one memory read per cycle through the single registered
// read port. At n = 1024 the upward path of an add from entry 1 visits 11 entries,
// and a range sum walks two paths. The lower-bound search needs each read result
// before choosing the next address, so a descent step that stays inside the tree
// passes through a read state and an evaluate state, and a step that falls outside
// passes through the read state only. A rejected add, or a search whose target is at
// or below zero, goes straight to the finish state. One request is in flight at a
// time; a finished response sits in an output register, and the next request is
// accepted while it waits.
module fenwick_tree_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fte_pkg::IDX_W-1:0]   cfg_data,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  fte_pkg::req_t               req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output fte_pkg::rsp_t               rsp_data
);
    import fte_pkg::*;

    logic [IDX_W-1:0]  size_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg;
    logic              rsp_free;
    logic              done;
    rsp_t              result;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    // Size register, written through its own channel.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    // Output register decouples the sequencer from the consumer.
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Sequencer.
    fte_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_free  (rsp_free),
        .done      (done),
        .result    (result),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Shared add and compare unit.
    fte_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Tree store.
    fte_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

### hw/rtl/fte_ram.sv
module fte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/fte_alu.sv
module fte_alu (
    input  fte_pkg::alu_req_t req,
    output fte_pkg::alu_rsp_t rsp
);
    import fte_pkg::*;

    logic [DATA_W:0] a_ext;
    logic [DATA_W:0] b_ext;
    logic [DATA_W:0] res;

    // Shared 33-bit add or subtract; the extra bit gives an exact signed compare.
    always_comb
    begin
        a_ext = {req.a[DATA_W-1], req.a};
        b_ext = {req.b[DATA_W-1], req.b};
        res   = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);
    end

    assign rsp.sum      = res[DATA_W-1:0];
    assign rsp.positive = !res[DATA_W] && (res != '0);

endmodule

### hw/rtl/fte_seq.sv
module fte_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fte_pkg::IDX_W-1:0]       size,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  fte_pkg::req_t                   req_data,
    input  logic                            rsp_free,
    output logic                            done,
    output fte_pkg::rsp_t                   result,
    output fte_pkg::alu_req_t               alu_req,
    input  fte_pkg::alu_rsp_t               alu_rsp,
    output fte_pkg::ram_req_t               ram_req,
    input  logic [fte_pkg::DATA_W-1:0]      ram_rdata
);
    import fte_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [WALK_W-1:0]  idx_reg, idx_next;
    logic [WALK_W-1:0]  k_reg, k_next;
    logic [WALK_W-1:0]  hi_reg, hi_next;
    logic [WALK_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               bad_reg, bad_next;
    logic               phase_reg, phase_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic [WALK_W-1:0]  n_w;
    logic [WALK_W-1:0]  lo_w;
    logic [WALK_W-1:0]  srch_p;
    logic [WALK_W-1:0]  x_plus_one;
    logic [IDX_W-1:0]   lo_minus_one;
    logic               accept;
    logic               add_bad;
    logic               target_low;
    logic               walk_issue;
    logic               walk_end;
    logic               srch_p_ok;
    logic               k_zero;

    // Shared conditions for the sequencer.
    assign n_w          = (WALK_W'(size) > N_MAX) ? N_MAX : WALK_W'(size);
    assign lo_w         = WALK_W'(req_data.index);
    assign lo_minus_one = req_data.index - IDX_W'(1);
    assign req_ready    = (state_reg == ST_IDLE);
    assign accept       = req_valid && req_ready;
    assign add_bad      = (lo_w == '0) || (lo_w > n_w);
    assign target_low   = req_data.value[DATA_W-1] || (req_data.value == '0);
    assign walk_issue   = (state_reg == ST_WALK) &&
                          ((op_reg == OP_ADD) ? (idx_reg <= n_w) : (idx_reg != '0));
    assign walk_end     = (state_reg == ST_WALK) && !walk_issue && !pend_reg;
    assign srch_p       = idx_reg + k_reg;
    assign srch_p_ok    = (srch_p <= n_w);
    assign k_zero       = (k_reg == '0);
    assign x_plus_one   = idx_reg + WALK_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.opcode)
                        OP_ADD:    state_next = add_bad ? ST_FINISH : ST_WALK;
                        OP_SEARCH: state_next = target_low ? ST_FINISH : ST_SRCH_RD;
                        default:   state_next = ST_WALK;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_end && !((op_reg == OP_RANGE) && !phase_reg))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SRCH_RD:
            begin
                if (k_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (srch_p_ok)
                begin
                    state_next = ST_SRCH_EV;
                end
            end
            ST_SRCH_EV:
            begin
                state_next = ST_SRCH_RD;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory and shared unit control.
    always_comb
    begin
        op_next       = op_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        hi_next       = hi_reg;
        pend_idx_next = pend_idx_reg;
        val_next      = val_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        bad_next      = bad_reg;
        phase_next    = phase_reg;
        pend_next     = 1'b0;
        clr_cnt_next  = clr_cnt_reg;

        ram_req       = '0;
        alu_req.a     = acc_reg;
        alu_req.b     = ram_rdata;
        alu_req.sub   = !phase_reg;
        done          = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_cnt_reg;
                ram_req.wdata = '0;
                clr_cnt_next  = clr_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req_data.opcode;
                    val_next = req_data.value;
                    acc_next = '0;
                    pos_next = '0;
                    bad_next = (req_data.opcode == OP_ADD) && add_bad;
                    k_next   = K_TOP;
                    hi_next  = clamp_idx(req_data.index_high, n_w);
                    // The low walk of a range subtracts, every other walk adds.
                    phase_next = (req_data.opcode != OP_RANGE);
                    case (req_data.opcode)
                        OP_ADD:    idx_next = lo_w;
                        OP_PREFIX: idx_next = clamp_idx(req_data.index, n_w);
                        OP_RANGE:
                        begin
                            idx_next = (req_data.index == '0) ? '0 :
                                       clamp_idx(lo_minus_one, n_w);
                        end
                        default:   idx_next = '0;
                    endcase
                end
            end
            ST_WALK:
            begin
                // Issue one read per cycle; the data returns in the next cycle.
                if (walk_issue)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = to_addr(idx_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = (op_reg == OP_ADD) ? (idx_reg + low_bit(idx_reg)) :
                                                         (idx_reg - low_bit(idx_reg));
                end
                if (op_reg == OP_ADD)
                begin
                    alu_req.a = val_reg;
                end
                if (pend_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = to_addr(pend_idx_reg);
                        ram_req.wdata = alu_rsp.sum;
                    end
                    else
                    begin
                        acc_next = alu_rsp.sum;
                    end
                end
                if (walk_end && (op_reg == OP_RANGE) && !phase_reg)
                begin
                    phase_next = 1'b1;
                    idx_next   = hi_reg;
                end
            end
            ST_SRCH_RD:
            begin
                if (k_zero)
                begin
                    pos_next = x_plus_one[IDX_W-1:0];
                end
                else if (srch_p_ok)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = to_addr(srch_p);
                end
                else
                begin
                    k_next = k_reg >> 1;
                end
            end
            ST_SRCH_EV:
            begin
                // Step into the node when its count is below the remaining target.
                alu_req.a   = val_reg;
                alu_req.sub = 1'b1;
                if (alu_rsp.positive)
                begin
                    val_next = alu_rsp.sum;
                    idx_next = srch_p;
                end
                k_next = k_reg >> 1;
            end
            ST_FINISH:
            begin
                done = rsp_free;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign result.sum_result = acc_reg;
    assign result.position   = pos_reg;
    assign result.bad_index  = bad_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            pend_reg    <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        hi_reg       <= hi_next;
        pend_idx_reg <= pend_idx_next;
        val_reg      <= val_next;
        acc_reg      <= acc_next;
        pos_reg      <= pos_next;
        bad_reg      <= bad_next;
        phase_reg    <= phase_next;
    end

    // A pending read slot always follows a read issued in the previous cycle.
    a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(ram_req.re))
        else $error("pending data without a preceding read");

    // The add walk never reads the entry it is writing back.
    a_no_rmw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("read and write hit the same entry");

    // A search evaluation only follows a step that stayed inside the tree.
    a_srch_ev_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_EV) |-> (!k_zero && srch_p_ok && $past(ram_req.re)))
        else $error("search evaluation outside the tree");

    // The search never writes the store.
    a_srch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SRCH_RD) || (state_reg == ST_SRCH_EV)) |-> !ram_req.we)
        else $error("store written during a search");

endmodule
